FILE: src/sacf_pkg.sv
package sacf_pkg;

  localparam int MAX_SET_BITS_DEF = 10;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_BITS_DEF    = 48;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int CNT_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAYS        = 2'd0,
    REG_INDEX_BITS  = 2'd1,
    REG_OFFSET_BITS = 2'd2,
    REG_LAYOUT      = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_OUTPUT
  } sacf_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear_en;
    logic accept;
    logic update;
  } sacf_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_done;
  } sacf_stat_t;

endpackage

FILE: src/sacf_if.sv
interface sacf_in_if #(parameter int ADDR_BITS = 48);
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [ADDR_BITS-1:0] address;
  modport source (output valid, cmd, address, input ready);
  modport sink   (input valid, cmd, address, output ready);
endinterface

interface sacf_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        mem_read;
  logic        mem_write;
  logic [31:0] total_hits;
  logic [31:0] total_misses;
  logic [31:0] total_mem_reads;
  logic [31:0] total_mem_writes;
  modport source (output valid, hit, mem_read, mem_write, total_hits, total_misses,
                  total_mem_reads, total_mem_writes, input ready);
  modport sink   (input valid, hit, mem_read, mem_write, total_hits, total_misses,
                  total_mem_reads, total_mem_writes, output ready);
endinterface

FILE: src/sacf_ram.sv
module sacf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/sacf_ctrl.sv
module sacf_ctrl
  import sacf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output sacf_cmd_t  cmd,
  input  sacf_stat_t stat
);
  sacf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.update = 1'b1;
        state_nxt  = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        out_valid = 1'b1;
        // The next item may be taken in the same cycle as the result leaves.
        if (out_ready) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_nxt  = ST_LOOKUP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

FILE: src/sacf_dp.sv
module sacf_dp
  import sacf_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_cmd,
  input  logic [ADDR_BITS-1:0]  in_address,
  input  sacf_cmd_t             cmd,
  output sacf_stat_t            stat,
  output logic                  hit,
  output logic                  mem_read,
  output logic                  mem_write,
  output logic [CNT_W-1:0]      total_hits,
  output logic [CNT_W-1:0]      total_misses,
  output logic [CNT_W-1:0]      total_mem_reads,
  output logic [CNT_W-1:0]      total_mem_writes
);
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int SH_W     = $clog2(ADDR_BITS + 1);
  localparam int ROW_W    = MAX_WAYS * (1 + ADDR_BITS);

  logic [3:0] ways_r, index_bits_r, offset_bits_r;
  logic       layout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r        <= 4'd1;
      index_bits_r  <= 4'd0;
      offset_bits_r <= 4'd6;
      layout_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WAYS:        ways_r        <= cfg_data;
        REG_INDEX_BITS:  index_bits_r  <= cfg_data;
        REG_OFFSET_BITS: offset_bits_r <= cfg_data;
        REG_LAYOUT:      layout_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective geometry.
  logic [WCNT_W-1:0] w_eff;
  logic [SH_W-1:0]   ib_eff, ob_eff, tw;
  always_comb begin
    if (ways_r == 4'd0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(ways_r) > MAX_WAYS) begin
      w_eff = WCNT_W'(MAX_WAYS);
    end else begin
      w_eff = WCNT_W'(ways_r);
    end
    ib_eff = (32'(index_bits_r) > MAX_SET_BITS) ? SH_W'(MAX_SET_BITS) : SH_W'(index_bits_r);
    ob_eff = SH_W'(offset_bits_r);
    tw = (32'(ib_eff) + 32'(ob_eff) < ADDR_BITS) ?
         SH_W'(ADDR_BITS - 32'(ib_eff) - 32'(ob_eff)) : '0;
  end

  // Address split.
  logic [ADDR_BITS-1:0] tag_c, set_full, tag_mask, set_mask;
  logic [SET_W-1:0]     set_c;
  always_comb begin
    tag_mask = (tw == '0) ? '0 : ({ADDR_BITS{1'b1}} >> (SH_W'(ADDR_BITS) - tw));
    set_mask = (ib_eff == '0) ? '0 : ({ADDR_BITS{1'b1}} >> (SH_W'(ADDR_BITS) - ib_eff));
    if (!layout_r) begin
      set_full = (in_address >> ob_eff) & set_mask;
      tag_c    = (in_address >> (ob_eff + ib_eff)) & tag_mask;
    end else begin
      set_full = (ib_eff == '0) ? '0 : (in_address >> (SH_W'(ADDR_BITS) - ib_eff));
      tag_c    = (in_address >> ob_eff) & tag_mask;
    end
    set_c = set_full[SET_W-1:0];
  end

  // Clearing pass over valid bits and pointers.
  logic [SET_W:0] clr_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_en && !stat.clear_done) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end
  assign stat.clear_done = (32'(clr_cnt_r) >= NUM_SETS);

  logic [ADDR_BITS-1:0] tag_r;
  logic [SET_W-1:0]     set_r;
  logic                 wr_r;
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_r <= tag_c;
      set_r <= set_c;
      wr_r  <= in_cmd;
    end
  end

  // One row per set: valid bits, tags and the FIFO pointer.
  logic                row_we;
  logic [SET_W-1:0]    row_waddr, row_raddr;
  logic [ROW_W+WAY_W-1:0] row_wdata, row_rdata;

  sacf_ram #(.WIDTH(ROW_W + WAY_W), .DEPTH(NUM_SETS)) u_rows (
    .clk  (clk),
    .we   (row_we),
    .waddr(row_waddr),
    .wdata(row_wdata),
    .raddr(row_raddr),
    .rdata(row_rdata)
  );
  assign row_raddr = set_c;

  logic [MAX_WAYS-1:0]  v_row;
  logic [ADDR_BITS-1:0] t_row [MAX_WAYS];
  logic [WAY_W-1:0]     ptr_row;
  logic                 hit_c, placed;
  logic [WAY_W-1:0]     fill_way, victim, ptr_new;
  logic [MAX_WAYS-1:0]  v_new;
  logic [ADDR_BITS-1:0] t_new [MAX_WAYS];

  always_comb begin
    for (int k = 0; k < MAX_WAYS; k++) begin
      v_row[k] = row_rdata[k*(1+ADDR_BITS) + ADDR_BITS];
      t_row[k] = row_rdata[k*(1+ADDR_BITS) +: ADDR_BITS];
    end
    ptr_row = row_rdata[ROW_W +: WAY_W];
    hit_c = 1'b0;
    placed = 1'b0;
    fill_way = '0;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (k < 32'(w_eff)) begin
        if (v_row[k] && t_row[k] == tag_r) hit_c = 1'b1;
        if (!v_row[k] && !placed) begin
          placed = 1'b1;
          fill_way = WAY_W'(k);
        end
      end
    end
    victim = (32'(ptr_row) >= 32'(w_eff)) ? '0 : ptr_row;
    ptr_new = (32'(victim) + 1 >= 32'(w_eff)) ? '0 : WAY_W'(32'(victim) + 1);
    v_new = v_row;
    for (int k = 0; k < MAX_WAYS; k++) t_new[k] = t_row[k];
    if (placed) begin
      v_new[fill_way] = 1'b1;
      t_new[fill_way] = tag_r;
      ptr_new = ptr_row;
    end else begin
      v_new[victim] = 1'b1;
      t_new[victim] = tag_r;
    end
    for (int k = 0; k < MAX_WAYS; k++) begin
      row_wdata[k*(1+ADDR_BITS) + ADDR_BITS]   = v_new[k];
      row_wdata[k*(1+ADDR_BITS) +: ADDR_BITS]  = t_new[k];
    end
    row_wdata[ROW_W +: WAY_W] = ptr_new;
    row_we    = cmd.update && !hit_c;
    row_waddr = set_r;
    if (cmd.clear_en) begin
      row_we    = !stat.clear_done;
      row_waddr = clr_cnt_r[SET_W-1:0];
      row_wdata = '0;
    end
  end

  logic [CNT_W-1:0] hits_r, misses_r, reads_r, writes_r;
  logic             hit_r, wr_o_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      reads_r  <= '0;
      writes_r <= '0;
    end else if (cmd.update) begin
      if (hit_c) begin
        hits_r <= hits_r + 1'b1;
      end else begin
        misses_r <= misses_r + 1'b1;
        reads_r  <= reads_r + 1'b1;
      end
      if (wr_r) writes_r <= writes_r + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit_r  <= hit_c;
      wr_o_r <= wr_r;
    end
  end

  assign hit              = hit_r;
  assign mem_read         = !hit_r;
  assign mem_write        = wr_o_r;
  assign total_hits       = hits_r;
  assign total_misses     = misses_r;
  assign total_mem_reads  = reads_r;
  assign total_mem_writes = writes_r;
endmodule

FILE: src/set_assoc_cache_fifo_sim_top.sv
// An accepted item passes the LOOKUP then OUTPUT state; the next item is taken
// only as its result leaves, which waits on out_ready.
// Each item needs a read of its set row and then an update of that row.
// Reset (synchronous, rst_n low) clears counters and sets the configuration to
// defaults, then a clearing pass zeroes 2**MAX_SET_BITS rows (1024 by default).
module set_assoc_cache_fifo_sim_top
  import sacf_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sacf_in_if.sink               in_ch,
  sacf_out_if.source            out_ch
);
  sacf_cmd_t  cmd;
  sacf_stat_t stat;

  sacf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sacf_dp #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_cmd          (in_ch.cmd),
    .in_address      (in_ch.address),
    .cmd             (cmd),
    .stat            (stat),
    .hit             (out_ch.hit),
    .mem_read        (out_ch.mem_read),
    .mem_write       (out_ch.mem_write),
    .total_hits      (out_ch.total_hits),
    .total_misses    (out_ch.total_misses),
    .total_mem_reads (out_ch.total_mem_reads),
    .total_mem_writes(out_ch.total_mem_writes)
  );
endmodule
